FILE: rtl/plm_pkg.sv
// Shared types and codes of the positional list engine.
package plm_pkg;

    localparam int POS_W     = 7;
    localparam int VAL_W     = 32;
    localparam int CNT_OUT_W = 7;

    typedef enum logic [1:0] {
        KIND_INSERT    = 2'd0,
        KIND_REMOVE    = 2'd1,
        KIND_READ      = 2'd2,
        KIND_OVERWRITE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SHIFT,
        S_INS_PUT,
        S_REM_SHIFT,
        S_READ,
        S_FINISH
    } state_t;

    typedef struct packed {
        kind_t                    kind;
        logic [POS_W-1:0]         position;
        logic signed [VAL_W-1:0]  value;
    } req_t;

    typedef struct packed {
        status_t                  status;
        logic signed [VAL_W-1:0]  read_value;
        logic [CNT_OUT_W-1:0]     entry_count;
        logic                     is_empty;
    } rsp_t;

endpackage

FILE: rtl/positional_list_engine.sv
// An insert at the back and a remove of the last entry skip the shift loop; a read
// waits for the registered read port of the entry store before its result beat.
// One request is worked at a time; the shift loop moves one entry per cycle through
// the single read and write port of the entry store.
// Reset clears the entry count and the handshake state; stored entries are not cleared.
// Top level of the positional list engine.
module positional_list_engine
    import plm_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int AW = $clog2(CAPACITY);

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [VAL_W-1:0] mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [VAL_W-1:0] mem_rdata;

    plm_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    plm_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

FILE: rtl/plm_mem.sv
// Entry store: one write port and one registered read port.
module plm_mem
    import plm_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [VAL_W-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [VAL_W-1:0] rdata
);

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/plm_seq.sv
// Request sequencer: checks, entry shifting through the store, and the result register.
module plm_seq
    import plm_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   req_valid,
    output logic                                   req_stall,
    input  req_t                                   req,
    output logic                                   rsp_valid,
    input  logic                                   rsp_stall,
    output rsp_t                                   rsp,
    output logic                                   mem_we,
    output logic [$clog2(CAPACITY)-1:0]            mem_waddr,
    output logic [VAL_W-1:0]                       mem_wdata,
    output logic [$clog2(CAPACITY)-1:0]            mem_raddr,
    input  logic [VAL_W-1:0]                       mem_rdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [AW-1:0]        addr_reg, addr_next;
    logic [AW-1:0]        pos_reg, pos_next;
    logic [VAL_W-1:0]     val_reg, val_next;
    status_t              status_reg, status_next;
    logic [VAL_W-1:0]     rd_reg, rd_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_t                 rsp_reg, rsp_next;

    logic [XW-1:0]        cnt_x, pos_x, cap_x, cnt_m1_x, addr_x;
    logic                 full, empty, pos_le, pos_lt, at_back, at_last, addr_last;
    logic                 rsp_free;
    status_t              req_status;

    assign cnt_x    = XW'(count_reg);
    assign pos_x    = XW'(req.position);
    assign cap_x    = XW'(CAPACITY);
    assign cnt_m1_x = cnt_x - XW'(1);
    assign addr_x   = XW'(addr_reg);

    assign full      = (cnt_x == cap_x);
    assign empty     = (count_reg == '0);
    assign pos_le    = (pos_x <= cnt_x);
    assign pos_lt    = (pos_x < cnt_x);
    assign at_back   = (pos_x == cnt_x);
    assign at_last   = (pos_x == cnt_m1_x);
    assign addr_last = (addr_x == cnt_m1_x);
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        if (req.kind == KIND_INSERT)
        begin
            if (full)
                req_status = ST_FULL;
            else if (!pos_le)
                req_status = ST_BAD_POS;
            else
                req_status = ST_OK;
        end
        else
        begin
            if (empty)
                req_status = ST_EMPTY;
            else if (!pos_lt)
                req_status = ST_BAD_POS;
            else
                req_status = ST_OK;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_status != ST_OK)
                        state_next = S_FINISH;
                    else
                    begin
                        case (req.kind)
                            KIND_INSERT:    state_next = at_back ? S_FINISH : S_INS_SHIFT;
                            KIND_REMOVE:    state_next = at_last ? S_FINISH : S_REM_SHIFT;
                            KIND_READ:      state_next = S_READ;
                            default:        state_next = S_FINISH;
                        endcase
                    end
                end
            end
            S_INS_SHIFT:
            begin
                if (addr_reg == pos_reg)
                    state_next = S_INS_PUT;
            end
            S_INS_PUT:   state_next = S_FINISH;
            S_REM_SHIFT:
            begin
                if (addr_last)
                    state_next = S_FINISH;
            end
            S_READ:      state_next = S_FINISH;
            S_FINISH:
            begin
                if (rsp_free)
                    state_next = S_IDLE;
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        addr_next      = addr_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        status_next    = status_reg;
        rd_next        = rd_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        mem_we         = 1'b0;
        mem_waddr      = addr_reg;
        mem_wdata      = mem_rdata;
        mem_raddr      = addr_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    pos_next    = pos_x[AW-1:0];
                    val_next    = req.value;
                    status_next = req_status;
                    rd_next     = '0;
                    if (req_status == ST_OK)
                    begin
                        case (req.kind)
                            KIND_INSERT:
                            begin
                                if (at_back)
                                begin
                                    mem_we     = 1'b1;
                                    mem_waddr  = pos_x[AW-1:0];
                                    mem_wdata  = req.value;
                                    count_next = count_reg + CW'(1);
                                end
                                else
                                begin
                                    mem_raddr = cnt_m1_x[AW-1:0];
                                    addr_next = cnt_m1_x[AW-1:0];
                                end
                            end
                            KIND_REMOVE:
                            begin
                                if (at_last)
                                    count_next = count_reg - CW'(1);
                                else
                                begin
                                    mem_raddr = pos_x[AW-1:0] + AW'(1);
                                    addr_next = pos_x[AW-1:0] + AW'(1);
                                end
                            end
                            KIND_READ:
                            begin
                                mem_raddr = pos_x[AW-1:0];
                            end
                            default:
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = pos_x[AW-1:0];
                                mem_wdata = req.value;
                            end
                        endcase
                    end
                end
            end
            S_INS_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_reg + AW'(1);
                if (addr_reg != pos_reg)
                begin
                    mem_raddr = addr_reg - AW'(1);
                    addr_next = addr_reg - AW'(1);
                end
            end
            S_INS_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = val_reg;
                count_next = count_reg + CW'(1);
            end
            S_REM_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_reg - AW'(1);
                if (addr_last)
                    count_next = count_reg - CW'(1);
                else
                begin
                    mem_raddr = addr_reg + AW'(1);
                    addr_next = addr_reg + AW'(1);
                end
            end
            S_READ:
            begin
                rd_next = mem_rdata;
            end
            S_FINISH:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = status_reg;
                    rsp_next.read_value  = rd_reg;
                    rsp_next.entry_count = cnt_x[CNT_OUT_W-1:0];
                    rsp_next.is_empty    = empty;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        rd_reg     <= rd_next;
        rsp_reg    <= rsp_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_x <= cap_x)
        else $error("entry count exceeds capacity");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (XW'(mem_waddr) <= cnt_x))
        else $error("store write beyond the occupied range");

    a_rsp_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result beat raised outside the finish step");

    a_shift_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REM_SHIFT || state_reg == S_INS_SHIFT) |-> !empty)
        else $error("shifting an empty list");

endmodule
